/* hw/rtl/vtse_pkg.sv */
`timescale 1ns / 1ps
package vtse_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 24;

  localparam int CHAR_W  = 8;
  localparam int CELL_W  = CHAR_W + 1;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int COUNT_W = 16;
  // signed cursor math: covers 256 + 255 and -255
  localparam int CALC_W  = 10;

  localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5b;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3f;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_H      = 8'h48;
  localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h42;
  localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D      = 8'h44;
  localparam logic [CHAR_W-1:0] CH_K      = 8'h4b;
  localparam logic [CHAR_W-1:0] CH_J      = 8'h4a;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h6d;

  localparam logic [CELL_W-1:0] CELL_BLANK = {1'b0, CH_SPACE};

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  localparam logic [1:0] PAD_IDLE   = 2'd0;
  localparam logic [1:0] PAD_DOLLAR = 2'd1;
  localparam logic [1:0] PAD_SKIP   = 2'd2;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

/* hw/rtl/vtse_ram.sv */
`timescale 1ns / 1ps
module vtse_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/vt100_text_screen_engine_top.sv */
`timescale 1ns / 1ps
// VT100 text screen engine. A request (start while busy is low) either feeds one byte to
// the terminal interpreter (op_i = 0) or reads one screen cell (op_i = 1). Exactly one result
// comes back per request, on done_o for a single cycle; the receiver cannot stall it. The screen
// lives in a single-port-write RAM with registered read, and one address counter walks it for
// every bulk operation. Erases blank up to ROWS*COLS cells; a scroll copies every row up by one
// and blanks the last row. After reset the RAM is blanked while busy is high.
module vt100_text_screen_engine_top #(
  parameter int SCREEN_COLS = vtse_pkg::DEF_COLS,
  parameter int SCREEN_ROWS = vtse_pkg::DEF_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [vtse_pkg::CHAR_W-1:0]   data_byte_i,
  input  logic [vtse_pkg::RROW_W-1:0]   read_row_i,
  input  logic [vtse_pkg::RCOL_W-1:0]   read_col_i,
  output logic                          done_o,
  output logic [vtse_pkg::CHAR_W-1:0]   cell_char_o,
  output logic                          cell_standout_o,
  output logic [vtse_pkg::RROW_W-1:0]   cursor_row_o,
  output logic [vtse_pkg::RCOL_W-1:0]   cursor_col_o,
  output logic [vtse_pkg::COUNT_W-1:0]  top_row_writes_o
);

  localparam int TOTAL  = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW     = $clog2(TOTAL);
  localparam int ADDR_W = $clog2(TOTAL + 1);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS + 1);
  localparam int CW     = vtse_pkg::CALC_W;

  localparam logic [ADDR_W-1:0] A_TOTAL = ADDR_W'(TOTAL);
  localparam logic [ADDR_W-1:0] A_COLS  = ADDR_W'(SCREEN_COLS);
  localparam logic [COL_W-1:0]  C_COLS  = COL_W'(SCREEN_COLS);
  localparam logic [ROW_W-1:0]  R_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic signed [CW-1:0] S_ROW_MAX = CW'(SCREEN_ROWS - 1);
  localparam logic signed [CW-1:0] S_COL_MAX = CW'(SCREEN_COLS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_PRINT = 8'b0000_0100,
    S_SCRL  = 8'b0000_1000,
    S_FILL  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_RDDAT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic                          op_q, op_d;
  logic [vtse_pkg::CHAR_W-1:0]   byte_q, byte_d;
  logic [vtse_pkg::RROW_W-1:0]   rrow_q, rrow_d;
  logic [vtse_pkg::RCOL_W-1:0]   rcol_q, rcol_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [COL_W-1:0]              col_q, col_d;
  logic                          so_q, so_d;
  logic [1:0]                    esc_q, esc_d, pad_q, pad_d, slot_q, slot_d;
  logic [7:0]                    par_q [4];
  logic [7:0]                    par_d [4];
  logic [vtse_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic [vtse_pkg::CELL_W-1:0]   cell_q, cell_d;
  logic                          redo_q, redo_d, pprint_q, pprint_d, init_q, init_d;
  logic                          rvalid_q, rvalid_d;
  logic [vtse_pkg::CHAR_W-1:0]   pchar_q, pchar_d;
  logic [ADDR_W-1:0]             addr_q, addr_d, end_q, end_d;

  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [vtse_pkg::CELL_W-1:0]   wdata, rdata;

  logic [ADDR_W-1:0]             base;
  logic [ADDR_W-1:0]             rd_base;
  logic                          rd_ok;
  logic [11:0]                   acc;
  logic [7:0]                    p0, p1, pcur;
  logic signed [CW-1:0]          nr, nc, sp0, sp1, n0;
  logic                          is_final;

  vtse_ram #(
    .WIDTH(vtse_pkg::CELL_W),
    .DEPTH(TOTAL)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign p0   = par_q[0];
  assign p1   = par_q[1];
  assign pcur = par_q[slot_q];
  assign base = ADDR_W'(ADDR_W'(row_q) * A_COLS) + ADDR_W'(col_q);
  assign rd_base = ADDR_W'(ADDR_W'(rrow_q) * A_COLS) + ADDR_W'(rcol_q);
  assign rd_ok = (CW'(rrow_q) < CW'(SCREEN_ROWS)) && (CW'(rcol_q) < CW'(SCREEN_COLS));
  assign acc  = 12'(pcur) * 12'd10 + 12'(byte_q - vtse_pkg::CH_ZERO);
  assign sp0  = CW'(p0);
  assign sp1  = CW'(p1);
  assign n0   = (p0 != 8'd0) ? sp0 : CW'(1);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    byte_d   = byte_q;
    rrow_d   = rrow_q;
    rcol_d   = rcol_q;
    row_d    = row_q;
    col_d    = col_q;
    so_d     = so_q;
    esc_d    = esc_q;
    pad_d    = pad_q;
    slot_d   = slot_q;
    par_d    = par_q;
    cnt_d    = cnt_q;
    cell_d   = cell_q;
    redo_d   = redo_q;
    pprint_d = pprint_q;
    init_d   = init_q;
    rvalid_d = rvalid_q;
    pchar_d  = pchar_q;
    addr_d   = addr_q;
    end_d    = end_q;
    we       = 1'b0;
    waddr    = addr_q[AW-1:0];
    wdata    = vtse_pkg::CELL_BLANK;
    raddr    = rd_base[AW-1:0];
    nr       = CW'(row_q);
    nc       = CW'(col_q);
    is_final = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d   = op_i;
          byte_d = data_byte_i;
          rrow_d = read_row_i;
          rcol_d = read_col_i;
          cell_d = '0;
          state_d = (op_i == vtse_pkg::OP_READ) ? S_RD : S_DISP;
        end
      end

      S_RD: begin
        state_d = S_RDDAT;
      end

      S_RDDAT: begin
        cell_d  = rd_ok ? rdata : '0;
        state_d = S_DONE;
      end

      S_DISP: begin
        state_d = S_DONE;
        if (pad_q == vtse_pkg::PAD_DOLLAR) begin
          if (byte_q == vtse_pkg::CH_LT) begin
            pad_d = vtse_pkg::PAD_SKIP;
          end else begin
            // lone '$': print it, then take this byte again
            pad_d    = vtse_pkg::PAD_IDLE;
            pchar_d  = vtse_pkg::CH_DOLLAR;
            redo_d   = 1'b1;
            pprint_d = 1'b1;
            state_d  = S_PRINT;
          end
        end else if (pad_q != vtse_pkg::PAD_IDLE) begin
          if (byte_q == vtse_pkg::CH_GT) pad_d = vtse_pkg::PAD_IDLE;
        end else if (byte_q == vtse_pkg::CH_DOLLAR && esc_q == vtse_pkg::ESC_IDLE) begin
          pad_d = vtse_pkg::PAD_DOLLAR;
        end else if (esc_q == vtse_pkg::ESC_SEEN) begin
          esc_d  = (byte_q == vtse_pkg::CH_LBRK) ? vtse_pkg::ESC_CSI : vtse_pkg::ESC_IDLE;
          slot_d = 2'd0;
          par_d[0] = 8'd0;
          par_d[1] = 8'd0;
        end else if (esc_q == vtse_pkg::ESC_CSI) begin
          if (byte_q >= vtse_pkg::CH_ZERO && byte_q <= vtse_pkg::CH_NINE) begin
            par_d[slot_q] = (acc > 12'd255) ? 8'd255 : acc[7:0];
          end else if (byte_q == vtse_pkg::CH_SEMI) begin
            if (slot_q != 2'd3) begin
              slot_d = slot_q + 2'd1;
              par_d[slot_q + 2'd1] = 8'd0;
            end
          end else if (byte_q != vtse_pkg::CH_QUEST) begin
            esc_d    = vtse_pkg::ESC_IDLE;
            is_final = 1'b1;
            case (byte_q)
              vtse_pkg::CH_H, vtse_pkg::CH_F: begin
                nr = (p0 != 8'd0) ? sp0 - CW'(1) : CW'(0);
                nc = (slot_q != 2'd0 && p1 != 8'd0) ? sp1 - CW'(1) : CW'(0);
              end
              vtse_pkg::CH_A: nr = CW'(row_q) - n0;
              vtse_pkg::CH_B: nr = CW'(row_q) + n0;
              vtse_pkg::CH_C: nc = CW'(col_q) + n0;
              vtse_pkg::CH_D: nc = CW'(col_q) - n0;
              vtse_pkg::CH_K: begin
                addr_d  = base;
                end_d   = ADDR_W'(ADDR_W'(row_q) * A_COLS) + A_COLS;
                state_d = S_FILL;
              end
              vtse_pkg::CH_J: begin
                if (p0 == 8'd2) begin
                  nr     = CW'(0);
                  nc     = CW'(0);
                  addr_d = '0;
                end else begin
                  addr_d = base;
                end
                end_d   = A_TOTAL;
                state_d = S_FILL;
              end
              vtse_pkg::CH_M: so_d = (p0 == 8'd7) || (p1 == 8'd7);
              default: ;
            endcase
          end
        end else begin
          case (byte_q)
            vtse_pkg::CH_ESC: esc_d = vtse_pkg::ESC_SEEN;
            vtse_pkg::CH_CR:  col_d = '0;
            vtse_pkg::CH_LF: begin
              col_d = '0;
              if (row_q != R_LAST) begin
                row_d = row_q + ROW_W'(1);
              end else begin
                addr_d   = A_COLS;
                rvalid_d = 1'b0;
                state_d  = S_SCRL;
              end
            end
            vtse_pkg::CH_BS: if (col_q != '0) col_d = col_q - COL_W'(1);
            vtse_pkg::CH_TAB: begin
              nc = (CW'(col_q) + CW'(8)) & ~CW'(7);
              col_d = (nc > S_COL_MAX) ? C_COLS : nc[COL_W-1:0];
            end
            default: begin
              if (byte_q >= vtse_pkg::CH_SPACE) begin
                pchar_d  = byte_q;
                pprint_d = 1'b1;
                state_d  = S_PRINT;
              end
            end
          endcase
        end
        if (is_final) begin
          row_d = (nr < 0) ? '0 : (nr > S_ROW_MAX) ? R_LAST : nr[ROW_W-1:0];
          col_d = (nc < 0) ? '0 : (nc > S_COL_MAX) ? C_COLS : nc[COL_W-1:0];
        end
      end

      S_PRINT: begin
        if (col_q >= C_COLS) begin
          col_d = '0;
          if (row_q != R_LAST) begin
            row_d = row_q + ROW_W'(1);
          end else begin
            addr_d   = A_COLS;
            rvalid_d = 1'b0;
            state_d  = S_SCRL;
          end
        end else begin
          we       = 1'b1;
          waddr    = base[AW-1:0];
          wdata    = {so_q, pchar_q};
          col_d    = col_q + COL_W'(1);
          pprint_d = 1'b0;
          if (row_q == '0) cnt_d = cnt_q + vtse_pkg::COUNT_W'(1);
          if (redo_q) begin
            redo_d  = 1'b0;
            state_d = S_DISP;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SCRL: begin
        // read cell n, write it in the next cycle to n - COLS
        raddr = addr_q[AW-1:0];
        we    = rvalid_q;
        waddr = AW'(addr_q - A_COLS - ADDR_W'(1));
        wdata = rdata;
        if (addr_q < A_TOTAL) begin
          addr_d   = addr_q + ADDR_W'(1);
          rvalid_d = 1'b1;
        end else begin
          rvalid_d = 1'b0;
          addr_d   = A_TOTAL - A_COLS;
          end_d    = A_TOTAL;
          state_d  = S_FILL;
        end
      end

      S_FILL: begin
        if (addr_q < end_q) begin
          we     = 1'b1;
          addr_d = addr_q + ADDR_W'(1);
        end else if (pprint_q) begin
          state_d = S_PRINT;
        end else if (init_q) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FILL;
      row_q    <= '0;
      col_q    <= '0;
      so_q     <= 1'b0;
      esc_q    <= vtse_pkg::ESC_IDLE;
      pad_q    <= vtse_pkg::PAD_IDLE;
      slot_q   <= 2'd0;
      par_q    <= '{default: 8'd0};
      cnt_q    <= '0;
      redo_q   <= 1'b0;
      pprint_q <= 1'b0;
      init_q   <= 1'b1;
      rvalid_q <= 1'b0;
      addr_q   <= '0;
      end_q    <= A_TOTAL;
      op_q     <= vtse_pkg::OP_FEED;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      so_q     <= so_d;
      esc_q    <= esc_d;
      pad_q    <= pad_d;
      slot_q   <= slot_d;
      par_q    <= par_d;
      cnt_q    <= cnt_d;
      redo_q   <= redo_d;
      pprint_q <= pprint_d;
      init_q   <= init_d;
      rvalid_q <= rvalid_d;
      addr_q   <= addr_d;
      end_q    <= end_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    rrow_q  <= rrow_d;
    rcol_q  <= rcol_d;
    cell_q  <= cell_d;
    pchar_q <= pchar_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign cell_char_o      = cell_q[vtse_pkg::CHAR_W-1:0];
  assign cell_standout_o  = cell_q[vtse_pkg::CHAR_W];
  assign cursor_row_o     = vtse_pkg::RROW_W'(CW'(row_q));
  assign cursor_col_o     = vtse_pkg::RCOL_W'(CW'(col_q));
  assign top_row_writes_o = cnt_q;

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("result strobe not followed by idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= C_COLS) && (row_q <= R_LAST))
    else $error("cursor out of range");

  a_feed_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q == vtse_pkg::OP_FEED) |-> (cell_q == '0))
    else $error("feed request returned cell data");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import vtse_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int N_ITEMS = 1640;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               so;
    logic [RROW_W-1:0]  row;
    logic [RCOL_W-1:0]  col;
    logic [COUNT_W-1:0] cnt;
  } screen_reply_t;

  class reply_scoreboard;
    screen_reply_t pending[$];
    int errors;

    function void note(screen_reply_t e);
      pending.push_back(e);
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check(screen_reply_t got);
      screen_reply_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.ch !== e.ch) report($sformatf("cell_char %0h exp %0h", got.ch, e.ch));
      if (got.so !== e.so) report($sformatf("cell_standout %0b exp %0b", got.so, e.so));
      if (got.row !== e.row) report($sformatf("cursor_row %0d exp %0d", got.row, e.row));
      if (got.col !== e.col) report($sformatf("cursor_col %0d exp %0d", got.col, e.col));
      if (got.cnt !== e.cnt) report($sformatf("top_row_writes %0d exp %0d", got.cnt, e.cnt));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = OP_FEED;
  logic [CHAR_W-1:0] data_byte_i = '0;
  logic [RROW_W-1:0] read_row_i = '0;
  logic [RCOL_W-1:0] read_col_i = '0;
  logic done_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic cell_standout_o;
  logic [RROW_W-1:0] cursor_row_o;
  logic [RCOL_W-1:0] cursor_col_o;
  logic [COUNT_W-1:0] top_row_writes_o;

  vt100_text_screen_engine_top u_dut (.*);

  reply_scoreboard sb = new();
  longint cycles = 0;
  int idle_pct = 0;
  int sent = 0;

  // shadow terminal state
  logic [CELL_W-1:0] scr [ROWS*COLS];
  int crow, ccol, slot, pv[4];
  logic so_mode;
  logic [1:0] esc_ph, pad_ph;
  logic [COUNT_W-1:0] top_cnt;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    screen_reply_t got;
    if (rst_ni && done_o) begin
      got = '{cell_char_o, cell_standout_o, cursor_row_o, cursor_col_o, top_row_writes_o};
      sb.check(got);
    end
  end

  function automatic void clip();
    if (crow < 0) crow = 0;
    if (crow >= ROWS) crow = ROWS - 1;
    if (ccol < 0) ccol = 0;
    if (ccol > COLS) ccol = COLS;
  endfunction

  function automatic void blank_to_end(int idx);
    for (int i = idx; i < ROWS*COLS; i++) scr[i] = CELL_BLANK;
  endfunction

  function automatic void new_line();
    ccol = 0;
    if (crow < ROWS - 1) crow++;
    else begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) scr[i] = scr[i+COLS];
      blank_to_end((ROWS-1)*COLS);
    end
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] c);
    if (ccol >= COLS) new_line();
    if (crow == 0) top_cnt++;
    scr[crow*COLS + ccol] = {so_mode, c};
    ccol++;
  endfunction

  function automatic void end_sequence(logic [CHAR_W-1:0] c);
    int n0;
    n0 = pv[0] ? pv[0] : 1;
    esc_ph = ESC_IDLE;
    case (c)
      CH_H, CH_F: begin
        crow = pv[0] ? pv[0] - 1 : 0;
        ccol = (slot != 0 && pv[1] != 0) ? pv[1] - 1 : 0;
      end
      CH_A: crow -= n0;
      CH_B: crow += n0;
      CH_C: ccol += n0;
      CH_D: ccol -= n0;
      CH_K: for (int x = ccol; x < COLS; x++) scr[crow*COLS + x] = CELL_BLANK;
      CH_J: begin
        if (pv[0] == 2) begin
          crow = 0;
          ccol = 0;
        end
        if (ccol < COLS) blank_to_end(crow*COLS + ccol);
        else if (crow + 1 < ROWS) blank_to_end((crow+1)*COLS);
      end
      CH_M: so_mode = (pv[0] == 7 || pv[1] == 7);
      default: ;
    endcase
    clip();
  endfunction

  function automatic void interp(logic [CHAR_W-1:0] c);
    int v;
    if (c == CH_DOLLAR && esc_ph == ESC_IDLE) begin
      pad_ph = PAD_DOLLAR;
      return;
    end
    if (esc_ph == ESC_SEEN) begin
      esc_ph = (c == CH_LBRK) ? ESC_CSI : ESC_IDLE;
      slot = 0;
      pv[0] = 0;
      pv[1] = 0;
      return;
    end
    if (esc_ph == ESC_CSI) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = pv[slot] * 10 + (c - CH_ZERO);
        pv[slot] = v > 255 ? 255 : v;
      end else if (c == CH_SEMI) begin
        if (slot < 3) begin
          slot++;
          pv[slot] = 0;
        end
      end else if (c != CH_QUEST) end_sequence(c);
      return;
    end
    case (c)
      CH_ESC: begin
        esc_ph = ESC_SEEN;
        return;
      end
      CH_CR: ccol = 0;
      CH_LF: new_line();
      CH_BS: if (ccol != 0) ccol--;
      CH_TAB: ccol = (ccol + 8) & ~7;
      default: begin
        if (c >= CH_SPACE) begin
          put_char(c);
          return;
        end
      end
    endcase
    clip();
  endfunction

  function automatic screen_reply_t predict(logic op, logic [CHAR_W-1:0] c,
                                            logic [RROW_W-1:0] r, logic [RCOL_W-1:0] k);
    screen_reply_t e;
    e = '0;
    if (op == OP_READ) begin
      if (r < ROWS && k < COLS) {e.so, e.ch} = scr[r*COLS + k];
    end else if (pad_ph == PAD_DOLLAR) begin
      if (c == CH_LT) pad_ph = PAD_SKIP;
      else begin
        pad_ph = PAD_IDLE;
        put_char(CH_DOLLAR);
        interp(c);
      end
    end else if (pad_ph != PAD_IDLE) begin
      if (c == CH_GT) pad_ph = PAD_IDLE;
    end else interp(c);
    e.row = crow[RROW_W-1:0];
    e.col = ccol[RCOL_W-1:0];
    e.cnt = top_cnt;
    return e;
  endfunction

  // one request; start stays high into the next call when no gap follows
  task automatic send(logic op, logic [CHAR_W-1:0] c, logic [RROW_W-1:0] r,
                      logic [RCOL_W-1:0] k);
    start <= 1'b1;
    op_i <= op;
    data_byte_i <= c;
    read_row_i <= r;
    read_col_i <= k;
    do @(posedge clk_i); while (busy);
    sb.note(predict(op, c, r, k));
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic feed(logic [CHAR_W-1:0] c);
    send(OP_FEED, c, RROW_W'($urandom), RCOL_W'($urandom));
  endtask

  task automatic read_cell();
    if ($urandom_range(9) == 0)
      send(OP_READ, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
    else send(OP_READ, CHAR_W'($urandom), RROW_W'($urandom_range(ROWS-1)),
              RCOL_W'($urandom_range(COLS-1)));
  endtask

  task automatic feed_number(int n);
    if (n >= 100) feed(CHAR_W'(CH_ZERO + n / 100));
    if (n >= 10) feed(CHAR_W'(CH_ZERO + (n / 10) % 10));
    feed(CHAR_W'(CH_ZERO + n % 10));
  endtask

  task automatic csi(int nparam);
    logic [CHAR_W-1:0] finals[10];
    finals = '{CH_H, CH_F, CH_A, CH_B, CH_C, CH_D, CH_K, CH_J, CH_M, CH_M};
    feed(CH_ESC);
    feed(CH_LBRK);
    if ($urandom_range(9) == 0) feed(CH_QUEST);
    for (int i = 0; i < nparam; i++) begin
      if (i != 0) feed(CH_SEMI);
      case ($urandom_range(3))
        0: feed_number($urandom_range(999));
        1: feed_number(7);
        2: feed_number(2);
        default: feed_number($urandom_range(30));
      endcase
    end
    if ($urandom_range(9) == 0) feed(CHAR_W'($urandom));
    else begin
      // erases walk the screen, keep them rare
      if ($urandom_range(3) != 0 && finals[$urandom_range(9)] inside {CH_J, CH_K})
        feed(CH_M);
      else feed(finals[$urandom_range(9)]);
    end
  endtask

  task automatic random_burst();
    int k;
    k = $urandom_range(99);
    if (k < 30) begin
      repeat ($urandom_range(1, 12)) feed(CHAR_W'($urandom_range(32, 255)));
    end else if (k < 50) csi($urandom_range(0, 5));
    else if (k < 70) read_cell();
    else if (k < 78) begin
      feed(CH_DOLLAR);
      if ($urandom_range(1)) begin
        feed(CH_LT);
        repeat ($urandom_range(0, 4)) feed(CHAR_W'($urandom));
        feed(CH_GT);
      end else feed(CHAR_W'($urandom));
    end else if (k < 90) begin
      case ($urandom_range(4))
        0: feed(CH_CR);
        1: feed(CH_LF);
        2: feed(CH_BS);
        3: feed(CH_TAB);
        default: feed(CHAR_W'($urandom_range(0, 31)));
      endcase
    end else feed(CHAR_W'($urandom));
  endtask

  initial begin
    int pct[4];
    pct = '{0, 62, 0, 7};
    for (int i = 0; i < ROWS*COLS; i++) scr[i] = CELL_BLANK;
    crow = 0;
    ccol = 0;
    slot = 0;
    pv = '{0, 0, 0, 0};
    so_mode = 1'b0;
    esc_ph = ESC_IDLE;
    pad_ph = PAD_IDLE;
    top_cnt = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    feed(8'h41);
    feed(8'hff);
    feed(8'h7f);
    feed(CH_DOLLAR);
    feed(8'h42);
    feed(CH_DOLLAR); feed(CH_LT); feed(8'h35); feed(CH_GT);
    feed(CH_ESC); feed(CH_LBRK); feed(8'h37); feed(CH_M);
    feed(8'h58);
    feed(CH_TAB); feed(CH_BS); feed(CH_CR); feed(CH_LF); feed(8'h00);
    send(OP_READ, 8'hff, 5'd0, 7'd0);
    send(OP_READ, 8'h00, 5'd31, 7'd127);
    send(OP_READ, 8'h00, 5'd23, 7'd79);
    feed(CH_ESC); feed(8'h41);

    while (sent < N_ITEMS) begin
      idle_pct = pct[(sent * 4) / N_ITEMS];
      random_burst();
    end
    csi(1);
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4 * ROWS * COLS) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/vtse_pkg.sv
hw/rtl/vtse_ram.sv
hw/rtl/vt100_text_screen_engine_top.sv
tb/testbench.sv
